// ===== src/jbs_pkg.sv =====
// Package for the JSON bracket scanner: beat payload types, scan state type,
// status codes, character codes and default limits. No dependencies.
`default_nettype none

package jbs_pkg;

  // Default limits
  localparam int unsigned MAX_DEPTH_DEF = 255;
  localparam int unsigned MAX_TEXT_DEF  = 65536;

  // Status codes
  localparam logic [2:0] ST_SCAN         = 3'd0;
  localparam logic [2:0] ST_MATCH        = 3'd1;
  localparam logic [2:0] ST_NOT_OPEN     = 3'd2;
  localparam logic [2:0] ST_WRONG_KIND   = 3'd3;
  localparam logic [2:0] ST_UNTERMINATED = 3'd4;
  localparam logic [2:0] ST_LIMIT        = 3'd5;
  localparam logic [2:0] ST_IGNORED      = 3'd6;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  // Input beat
  typedef struct packed {
    logic [7:0] text_byte;
    logic       first_byte;
  } jbs_in_t;

  // Result beat
  typedef struct packed {
    logic [2:0]  status;
    logic        top_separator;
    logic [15:0] element_count;
    logic [15:0] byte_offset;
  } jbs_out_t;

  // Scan state carried from byte to byte
  typedef struct packed {
    logic        inside_string;
    logic        escape_pending;
    logic [7:0]  nest_depth;
    logic        open_is_brace;
    logic        scan_done;
    logic [15:0] position;
    logic [15:0] separator_tally;
  } jbs_state_t;

endpackage

`default_nettype wire

// ===== src/jbs_step.sv =====
// Per-byte scan step: next scan state and result beat from current state
// and one input beat. Depends on jbs_pkg.
`default_nettype none

module jbs_step #(
  parameter int unsigned MAX_DEPTH = jbs_pkg::MAX_DEPTH_DEF,
  parameter int unsigned MAX_TEXT  = jbs_pkg::MAX_TEXT_DEF
) (
  input  jbs_pkg::jbs_state_t st,
  input  jbs_pkg::jbs_in_t    din,
  output jbs_pkg::jbs_state_t st_nxt,
  output jbs_pkg::jbs_out_t   dout
);
  import jbs_pkg::*;

  // Effective limits: depth fits 8 bits, offset fits 16 bits
  localparam int unsigned DepthCapI = (MAX_DEPTH < 255) ? MAX_DEPTH : 255;
  localparam int unsigned TextCapI  = (MAX_TEXT < 65536) ? MAX_TEXT : 65536;
  localparam logic [7:0]  DepthCap  = DepthCapI[7:0];
  localparam logic [16:0] TextCap   = TextCapI[16:0];

  logic [7:0]  c;
  logic [16:0] next_pos;
  logic [7:0]  depth_dec;
  logic        is_open;
  logic        fits;
  logic [15:0] tally_inc;

  assign c         = din.text_byte;
  assign next_pos  = {1'b0, st.position} + 17'd1;
  assign depth_dec = st.nest_depth - 8'd1;
  assign is_open   = (c == CH_LBRACE) || (c == CH_LBRACK);
  assign fits      = st.open_is_brace ? (c == CH_RBRACE) : (c == CH_RBRACK);
  assign tally_inc = (st.separator_tally == 16'hFFFF) ? 16'hFFFF
                                                      : st.separator_tally + 16'd1;

  always_comb begin
    st_nxt             = st;
    dout.status        = ST_SCAN;
    dout.top_separator = 1'b0;
    dout.element_count = 16'd0;
    dout.byte_offset   = 16'd0;

    if (din.first_byte) begin
      // New scan: opener sets depth one, anything else fails at once
      st_nxt.inside_string   = 1'b0;
      st_nxt.escape_pending  = 1'b0;
      st_nxt.position        = 16'd0;
      st_nxt.separator_tally = 16'd0;
      st_nxt.open_is_brace   = (c == CH_LBRACE);
      st_nxt.nest_depth      = is_open ? 8'd1 : 8'd0;
      st_nxt.scan_done       = !is_open;
      dout.status            = is_open ? ST_SCAN : ST_NOT_OPEN;
    end else if (st.scan_done) begin
      dout.status = ST_IGNORED;
    end else if (next_pos >= TextCap) begin
      // Text too long; offset saturates at 16 bits
      st_nxt.scan_done = 1'b1;
      dout.status      = ST_LIMIT;
      dout.byte_offset = next_pos[16] ? 16'hFFFF : next_pos[15:0];
    end else begin
      st_nxt.position  = next_pos[15:0];
      dout.byte_offset = next_pos[15:0];
      if (c == CH_NUL) begin
        st_nxt.scan_done = 1'b1;
        dout.status      = ST_UNTERMINATED;
      end else if (st.escape_pending) begin
        st_nxt.escape_pending = 1'b0;
      end else if (c == CH_QUOTE) begin
        st_nxt.inside_string = !st.inside_string;
      end else if (st.inside_string) begin
        if (c == CH_BSLASH) begin
          st_nxt.escape_pending = 1'b1;
        end
      end else if (is_open) begin
        if (st.nest_depth >= DepthCap) begin
          st_nxt.scan_done = 1'b1;
          dout.status      = ST_LIMIT;
        end else begin
          st_nxt.nest_depth = st.nest_depth + 8'd1;
        end
      end else if ((c == CH_RBRACE) || (c == CH_RBRACK)) begin
        st_nxt.nest_depth = depth_dec;
        if (depth_dec == 8'd0) begin
          st_nxt.scan_done = 1'b1;
          if (!fits) begin
            dout.status = ST_WRONG_KIND;
          end else begin
            dout.status        = ST_MATCH;
            dout.element_count = (next_pos == 17'd1) ? 16'd0 : tally_inc;
          end
        end
      end else if ((c == CH_COMMA) && (st.nest_depth == 8'd1)) begin
        st_nxt.separator_tally = tally_inc;
        dout.top_separator     = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/json_bracket_scanner_core.sv =====
// Top level of the JSON bracket scanner: input register, scan state,
// result register. Depends on jbs_pkg and jbs_step.
`default_nettype none

// Scans JSON text one byte per beat and returns one result beat per input
// beat: a status, a top-level comma flag, the element count on a match and
// the byte offset from the opener. A beat with first_byte set starts a new
// scan. Throughput is one byte per clock while the result side does not
// stall. Each input beat passes an input register and then a result
// register before its result beat goes valid.
// The per-byte state update is a single step of flag and counter logic, so
// back-to-back bytes flow without stalls unless the result side stalls.
module json_bracket_scanner_core #(
  parameter int unsigned MAX_DEPTH = jbs_pkg::MAX_DEPTH_DEF,
  parameter int unsigned MAX_TEXT  = jbs_pkg::MAX_TEXT_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  jbs_pkg::jbs_in_t   in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output jbs_pkg::jbs_out_t  out_data
);
  import jbs_pkg::*;

  logic       in_v_r;
  jbs_in_t    in_data_r;
  logic       out_v_r;
  jbs_out_t   out_data_r;
  jbs_state_t state_r;
  jbs_state_t state_nxt;
  jbs_out_t   res_nxt;
  logic       advance;

  // Step logic
  jbs_step #(
    .MAX_DEPTH (MAX_DEPTH),
    .MAX_TEXT  (MAX_TEXT)
  ) u_step (
    .st     (state_r),
    .din    (in_data_r),
    .st_nxt (state_nxt),
    .dout   (res_nxt)
  );

  // Handshake: move a beat forward when the result slot is free or drains
  assign advance   = in_v_r && (!out_v_r || out_ready);
  assign in_ready  = !in_v_r || advance;
  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
  end

  // Scan state, idle after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{inside_string: 1'b0, escape_pending: 1'b0, nest_depth: 8'd0,
                   open_is_brace: 1'b0, scan_done: 1'b1, position: 16'd0,
                   separator_tally: 16'd0};
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire
